// ----- hdl/pcov_pkg.sv -----
// Shared types and constants for the postage stamp coverage unit.
// No dependencies; imported by pcov_step_unit and postage_stamp_coverage_unit.
`default_nettype none

package pcov_pkg;

   // Field widths
   localparam int DENOM_W = 8;   // one stamp denomination
   localparam int COV_W   = 12;  // coverage value and table value counter
   localparam int STAMP_W = 4;   // stamp count held per table entry
   localparam int BEST_W  = 5;   // running minimum, one code above the largest count

   // Largest value the table is ever walked to
   localparam int COV_CAP = 4095;

   // Running minimum start: no combination found yet
   localparam logic [BEST_W-1:0] BEST_NONE = 5'd16;

   // Register reset value
   localparam logic [STAMP_W-1:0] MAX_STAMPS_RST = 4'd1;

   // Parameter defaults
   localparam int DEF_MAX_DENOMS  = 16;
   localparam int DEF_TABLE_DEPTH = 4096;

   // Control from the sequencer to the step unit
   typedef struct packed {
      logic issue;  // a denomination read was issued this cycle
      logic clear;  // restart the running minimum for a new value
   } pcov_step_ctl_type;

endpackage : pcov_pkg

`default_nettype wire

// ----- hdl/pcov_ram.sv -----
// Simple single-port-write, single-port-read memory with registered read data.
// Depends on nothing; used for the denomination store and the stamp table.
`default_nettype none

module pcov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule : pcov_ram

`default_nettype wire

// ----- hdl/pcov_step_unit.sv -----
// Shared compare/subtract and minimum unit of the coverage walk.
// Depends on pcov_pkg; driven by the sequencer in postage_stamp_coverage_unit.
`default_nettype none

module pcov_step_unit #(
   parameter int TBL_AW = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pcov_pkg::pcov_step_ctl_type   ctl,
   input  wire logic [pcov_pkg::COV_W-1:0]    value,
   input  wire logic [pcov_pkg::DENOM_W-1:0]  denom,
   input  wire logic [pcov_pkg::STAMP_W-1:0]  tbl_data,
   output logic      [TBL_AW-1:0]             tbl_addr,
   output logic      [pcov_pkg::BEST_W-1:0]   best,
   output logic                               busy
);

   import pcov_pkg::*;

   logic              s1_vld_ff;
   logic              s2_vld_ff;
   logic              s2_skip_ff;
   logic              s2_one_ff;
   logic [BEST_W-1:0] best_ff;
   logic [BEST_W-1:0] best_in;

   logic [COV_W-1:0]  denom_ext;
   logic [COV_W-1:0]  diff;
   logic              skip;
   logic              one;
   logic [BEST_W-1:0] cand;
   logic              take;

   // Stage 1: compare denomination with value, form the remainder address
   assign denom_ext = {{(COV_W-DENOM_W){1'b0}}, denom};
   assign diff      = value - denom_ext;
   assign skip      = (denom == '0) || (denom_ext > value);
   assign one       = (denom_ext == value);
   assign tbl_addr  = diff[TBL_AW-1:0];

   // Stage 2: candidate count and running minimum
   always_comb begin
      if (s2_one_ff) begin
         cand = BEST_W'(1);
      end else begin
         cand = {1'b0, tbl_data} + BEST_W'(1);
      end
      take = s2_vld_ff && !s2_skip_ff && (s2_one_ff || (tbl_data != '0)) && (cand < best_ff);
      if (ctl.clear) begin
         best_in = BEST_NONE;
      end else if (take) begin
         best_in = cand;
      end else begin
         best_in = best_ff;
      end
   end

   // Advance the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         best_ff   <= BEST_NONE;
      end else begin
         s1_vld_ff <= ctl.issue;
         s2_vld_ff <= s1_vld_ff;
         best_ff   <= best_in;
      end
      s2_skip_ff <= skip;
      s2_one_ff  <= one;
   end

   assign best = best_ff;
   assign busy = s1_vld_ff || s2_vld_ff;

   // Checks
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |-> !busy)
      else $error("running minimum cleared while steps are in flight");
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      best_ff != '0 && best_ff <= BEST_NONE)
      else $error("running minimum out of range");
   a_issue_flow: assert property (@(posedge clock) disable iff (reset)
      ctl.issue |=> s1_vld_ff ##1 s2_vld_ff)
      else $error("issued step lost in pipeline");

endmodule : pcov_step_unit

`default_nettype wire

// ----- hdl/postage_stamp_coverage_unit.sv -----
// Postage stamp coverage unit: takes a set of stamp denominations, one per
// transaction with the last one marked, then walks the values 1, 2, ... and for
// each value tries every stored denomination through one shared step unit,
// keeping the fewest stamps per value in an on-chip table. It returns the
// largest V such that 1..V are all reachable with at most max_stamps stamps,
// clipped at min(TABLE_DEPTH-1, 4095) with saturated set. Loading stores each
// denomination as its transaction is accepted. After the marked transaction each
// table value is handled by reading the N stored denominations, one per cycle,
// through the three-deep read/compare pipeline and then draining it; the walk
// ends at the first unreachable value. A set whose largest denomination is
// zero, or max_stamps of zero, returns coverage 0 at once. The table needs no
// clearing pass: every entry whose data is used was written earlier in the same
// walk. Input is stalled from the marked transaction until the result is taken.
// Depends on pcov_pkg, pcov_ram and pcov_step_unit.
`default_nettype none

module postage_stamp_coverage_unit #(
   parameter int MAX_DENOMS  = pcov_pkg::DEF_MAX_DENOMS,
   parameter int TABLE_DEPTH = pcov_pkg::DEF_TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [pcov_pkg::STAMP_W-1:0]  csr_wr_data,
   // Denomination transactions
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pcov_pkg::DENOM_W-1:0]  req_denomination,
   input  wire logic                          req_last_in_set,
   // Result transactions
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [pcov_pkg::COV_W-1:0]    rsp_coverage,
   output logic                               rsp_saturated
);

   import pcov_pkg::*;

   localparam int CNT_W       = $clog2(MAX_DENOMS + 1);
   localparam int IDX_W       = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
   localparam int TBL_ENTRIES = (TABLE_DEPTH > COV_CAP + 1) ? COV_CAP + 1 : TABLE_DEPTH;
   localparam int TBL_AW      = $clog2(TBL_ENTRIES);
   localparam logic [COV_W-1:0] LIMIT     = COV_W'(TBL_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_DENOMS);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DENOM_W-1:0]   largest_ff, largest_in;
   logic [STAMP_W-1:0]   max_stamps_ff, max_stamps_in;
   logic [COV_W-1:0]     value_ff, value_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [COV_W-1:0]     cover_ff, cover_in;
   logic                 sat_ff, sat_in;

   logic                 req_accept;
   logic                 den_we;
   logic                 tbl_we;
   pcov_step_ctl_type    ctl;

   logic [DENOM_W-1:0]   den_rdata;
   logic [STAMP_W-1:0]   tbl_rdata;
   logic [TBL_AW-1:0]    tbl_raddr;
   logic [BEST_W-1:0]    best;
   logic                 busy;
   logic                 best_ok;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign best_ok    = (best <= {1'b0, max_stamps_ff});

   // Sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      largest_in    = largest_ff;
      max_stamps_in = max_stamps_ff;
      value_in      = value_ff;
      k_in          = k_ff;
      cover_in      = cover_ff;
      sat_in        = sat_ff;
      den_we        = 1'b0;
      tbl_we        = 1'b0;
      ctl.issue     = 1'b0;
      ctl.clear     = 1'b0;

      if (csr_wr_en) begin
         max_stamps_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               // Store the denomination unless the store is full
               if (count_ff < CNT_FULL) begin
                  den_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (req_denomination > largest_ff) begin
                     largest_in = req_denomination;
                  end
               end
               if (req_last_in_set) begin
                  if ((largest_in == '0) || (max_stamps_ff == '0)) begin
                     // Nothing reachable
                     cover_in = '0;
                     sat_in   = 1'b0;
                     state_in = ST_RESULT;
                  end else begin
                     value_in  = COV_W'(1);
                     k_in      = '0;
                     ctl.clear = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Issue one denomination read per cycle
            ctl.issue = 1'b1;
            if (k_ff == count_ff - CNT_W'(1)) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               if (best_ok) begin
                  tbl_we = 1'b1;
                  if (value_ff == LIMIT) begin
                     cover_in = LIMIT;
                     sat_in   = 1'b1;
                     state_in = ST_RESULT;
                  end else begin
                     value_in  = value_ff + COV_W'(1);
                     ctl.clear = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end else begin
                  cover_in = value_ff - COV_W'(1);
                  sat_in   = 1'b0;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_RESULT: begin
            // Hold the result until taken, then ready for the next set
            if (!rsp_stall) begin
               count_in   = '0;
               largest_in = '0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         largest_ff    <= '0;
         max_stamps_ff <= MAX_STAMPS_RST;
         value_ff      <= '0;
         k_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         largest_ff    <= largest_in;
         max_stamps_ff <= max_stamps_in;
         value_ff      <= value_in;
         k_ff          <= k_in;
      end
      cover_ff <= cover_in;
      sat_ff   <= sat_in;
   end

   assign rsp_valid     = (state_ff == ST_RESULT);
   assign rsp_coverage  = cover_ff;
   assign rsp_saturated = sat_ff;

   // Denomination store
   pcov_ram #(
      .WIDTH (DENOM_W),
      .DEPTH (MAX_DENOMS),
      .AW    (IDX_W)
   ) u_denom_ram (
      .clock      (clock),
      .wr_en      (den_we),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    (req_denomination),
      .rd_addr    (k_ff[IDX_W-1:0]),
      .rd_data_ff (den_rdata)
   );

   // Fewest-stamps table
   pcov_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (TBL_ENTRIES),
      .AW    (TBL_AW)
   ) u_table_ram (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (value_ff[TBL_AW-1:0]),
      .wr_data    (best[STAMP_W-1:0]),
      .rd_addr    (tbl_raddr),
      .rd_data_ff (tbl_rdata)
   );

   // Shared compare and minimum unit
   pcov_step_unit #(
      .TBL_AW (TBL_AW)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .value    (value_ff),
      .denom    (den_rdata),
      .tbl_data (tbl_rdata),
      .tbl_addr (tbl_raddr),
      .best     (best),
      .busy     (busy)
   );

   // Checks
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_coverage == LIMIT)
      else $error("saturated result below the table limit");
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> k_ff < count_ff)
      else $error("denomination index beyond stored count");
   a_table_write: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> best != '0 && best <= {1'b0, max_stamps_ff})
      else $error("table entry written with an invalid stamp count");
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> value_ff != '0 && value_ff <= LIMIT)
      else $error("walked value outside the table");

endmodule : postage_stamp_coverage_unit

`default_nettype wire
